### src/bbpb_pkg.sv
// Shared types and constants for the bloom bright-pass box-blur block.
`default_nettype none
package bbpb_pkg;

  localparam int PIX_W   = 16;
  localparam int OUT_W   = 13;
  localparam int RW_W    = 13;
  localparam int SUM_W   = 18;
  localparam int BLUR_W  = 16;
  localparam int SCALE_W = 20;
  localparam int FRAC_W  = 12;

  localparam int DIV3_SHIFT = 19;
  localparam int DIV3_PROD_W = 2 * SUM_W;
  localparam logic [SUM_W-1:0] DIV3_RECIP = SUM_W'(174763);

  localparam logic [OUT_W-1:0] ONE_Q12 = OUT_W'(4096);

  localparam logic [RW_W-1:0]  RESET_ROW_WIDTH = RW_W'(1024);
  localparam logic [PIX_W-1:0] RESET_THRESHOLD = PIX_W'(4096);
  localparam logic [PIX_W-1:0] RESET_GAIN      = PIX_W'(4096);

  typedef enum logic [1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic s1_ld;
    logic s2_ld;
    logic s3_ld;
    logic o_ld;
  } stage_ld_t;

endpackage
`default_nettype wire

### src/bbpb_lane.sv
// Arithmetic lane: divide by three, apply gain, add original and saturate.
`default_nettype none
module bbpb_lane (
  input  wire logic                       clk_i,
  input  wire bbpb_pkg::stage_ld_t        ld_i,
  input  wire logic [bbpb_pkg::PIX_W-1:0] gain_i,
  input  wire logic [bbpb_pkg::PIX_W-1:0] orig_i,
  input  wire logic [bbpb_pkg::SUM_W-1:0] sum_i,
  output logic      [bbpb_pkg::OUT_W-1:0] pixel_o
);

  logic [bbpb_pkg::PIX_W-1:0]       s1_orig_q;
  logic [bbpb_pkg::SUM_W-1:0]       s1_sum_q;
  logic [bbpb_pkg::PIX_W-1:0]       s2_orig_q;
  logic [bbpb_pkg::BLUR_W-1:0]      s2_blur_q;
  logic [bbpb_pkg::PIX_W-1:0]       s3_orig_q;
  logic [bbpb_pkg::SCALE_W-1:0]     s3_scaled_q;
  logic [bbpb_pkg::OUT_W-1:0]       pix_q;

  logic [bbpb_pkg::DIV3_PROD_W-1:0] div_prod;
  logic [bbpb_pkg::BLUR_W-1:0]      blur_d;
  logic [2*bbpb_pkg::PIX_W-1:0]     gain_prod;
  logic [bbpb_pkg::SCALE_W-1:0]     scaled_d;
  logic [bbpb_pkg::SCALE_W:0]       total;
  logic [bbpb_pkg::OUT_W-1:0]       pix_d;

  assign div_prod  = bbpb_pkg::DIV3_PROD_W'(s1_sum_q)
                   * bbpb_pkg::DIV3_PROD_W'(bbpb_pkg::DIV3_RECIP);
  assign blur_d    = div_prod[bbpb_pkg::DIV3_SHIFT +: bbpb_pkg::BLUR_W];
  assign gain_prod = (2*bbpb_pkg::PIX_W)'(s2_blur_q) * (2*bbpb_pkg::PIX_W)'(gain_i);
  assign scaled_d  = gain_prod[bbpb_pkg::FRAC_W +: bbpb_pkg::SCALE_W];
  assign total     = (bbpb_pkg::SCALE_W+1)'(s3_orig_q) + (bbpb_pkg::SCALE_W+1)'(s3_scaled_q);

  always_comb begin
    if (total > (bbpb_pkg::SCALE_W+1)'(bbpb_pkg::ONE_Q12)) begin
      pix_d = bbpb_pkg::ONE_Q12;
    end else begin
      pix_d = total[bbpb_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1_ld) begin
      s1_orig_q <= orig_i;
      s1_sum_q  <= sum_i;
    end
    if (ld_i.s2_ld) begin
      s2_orig_q <= s1_orig_q;
      s2_blur_q <= blur_d;
    end
    if (ld_i.s3_ld) begin
      s3_orig_q   <= s2_orig_q;
      s3_scaled_q <= scaled_d;
    end
    if (ld_i.o_ld) begin
      pix_q <= pix_d;
    end
  end

  assign pixel_o = pix_q;

endmodule
`default_nettype wire

### src/bloom_bright_pass_box_blur.sv
// Top level: bright pass, window state, elastic pipeline and output serializer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | sink      | in_valid_i / in_stall_o    | pixel_in_i
//  out     | source    | out_valid_o / out_stall_i  | pixel_out_o, row_end_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One pixel is accepted per cycle while in_stall_o is low; a result is registered in
// s1, s2, s3 and then the output register. The last pixel of a row yields two results,
// which leave the output register in turn, so a full row of N pixels gives N results.
// Each stage is elastic: bubbles fill while the output is stalled.
// Reset clears the window state and all valid bits; config takes effect at once.
`default_nettype none
module bloom_bright_pass_box_blur #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [bbpb_pkg::PIX_W-1:0] pixel_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [bbpb_pkg::OUT_W-1:0] pixel_out_o,
  output logic                            row_end_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [bbpb_pkg::PIX_W-1:0] cfg_data_i
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP_W = (COL_W + 1 > bbpb_pkg::RW_W) ? COL_W + 1 : bbpb_pkg::RW_W;
  localparam int PIX_KEEP = (PIXEL_BITS < bbpb_pkg::PIX_W) ? PIXEL_BITS : bbpb_pkg::PIX_W;
  localparam logic [bbpb_pkg::PIX_W-1:0] PIX_MASK =
    bbpb_pkg::PIX_W'(((bbpb_pkg::PIX_W+1)'(1) << PIX_KEEP) - (bbpb_pkg::PIX_W+1)'(1));

  logic [bbpb_pkg::RW_W-1:0]  row_width_q;
  logic [bbpb_pkg::PIX_W-1:0] threshold_q;
  logic [bbpb_pkg::PIX_W-1:0] gain_q;

  logic [COL_W-1:0]           column_q, column_d;
  logic [bbpb_pkg::PIX_W-1:0] bp_q, bp2_q, bp2_d, orig_prev_q;

  logic [1:0] s1v_q, s2v_q, s3v_q, ov_q;
  logic [1:0] s1v_d, s2v_d, s3v_d, ov_d;

  logic [WCMP_W-1:0]          rw_ext, eff_w, col_next;
  logic                       last, col0;
  logic [bbpb_pkg::PIX_W-1:0] pix, bright;
  logic [bbpb_pkg::SUM_W-1:0] sum0, sum1;

  logic in_acc, pop, o_free, s3_mv, s3_free, s2_mv, s2_free, s1_mv, s1_free;
  bbpb_pkg::stage_ld_t ld;
  logic [bbpb_pkg::OUT_W-1:0] lane0_pix, lane1_pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= bbpb_pkg::RESET_ROW_WIDTH;
      threshold_q <= bbpb_pkg::RESET_THRESHOLD;
      gain_q      <= bbpb_pkg::RESET_GAIN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bbpb_pkg::CFG_ROW_WIDTH: row_width_q <= cfg_data_i[bbpb_pkg::RW_W-1:0];
        bbpb_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        bbpb_pkg::CFG_GAIN:      gain_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: effective width, row position and bright pass
  always_comb begin
    rw_ext = WCMP_W'(row_width_q);
    if (rw_ext == '0) begin
      eff_w = WCMP_W'(1);
    end else if (rw_ext > WCMP_W'(MAX_WIDTH)) begin
      eff_w = WCMP_W'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
  end

  assign col_next = WCMP_W'(column_q) + WCMP_W'(1);
  assign last     = (col_next >= eff_w);
  assign column_d = last ? '0 : col_next[COL_W-1:0];
  assign col0     = (column_q == '0);

  assign pix    = pixel_in_i & PIX_MASK;
  assign bright = (pix > threshold_q) ? pix : '0;
  assign bp2_d  = col0 ? bright : bp_q;
  assign sum0   = bbpb_pkg::SUM_W'(bp2_q) + bbpb_pkg::SUM_W'(bp_q)
                + bbpb_pkg::SUM_W'(bright);
  assign sum1   = bbpb_pkg::SUM_W'(bp2_d) + {1'b0, bright, 1'b0};

  // Elastic stage control
  assign pop     = out_valid_o && !out_stall_i;
  assign o_free  = (ov_q == 2'b00) || (pop && (ov_q != 2'b11));
  assign s3_mv   = (|s3v_q) && o_free;
  assign s3_free = !(|s3v_q) || s3_mv;
  assign s2_mv   = (|s2v_q) && s3_free;
  assign s2_free = !(|s2v_q) || s2_mv;
  assign s1_mv   = (|s1v_q) && s2_free;
  assign s1_free = !(|s1v_q) || s1_mv;
  assign in_acc  = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  assign ld.s1_ld = in_acc;
  assign ld.s2_ld = s1_mv;
  assign ld.s3_ld = s2_mv;
  assign ld.o_ld  = s3_mv;

  always_comb begin
    s1v_d = s1v_q;
    if (in_acc) begin
      s1v_d = {last, !col0};
    end else if (s1_mv) begin
      s1v_d = 2'b00;
    end
    s2v_d = s2v_q;
    if (s1_mv) begin
      s2v_d = s1v_q;
    end else if (s2_mv) begin
      s2v_d = 2'b00;
    end
    s3v_d = s3v_q;
    if (s2_mv) begin
      s3v_d = s2v_q;
    end else if (s3_mv) begin
      s3v_d = 2'b00;
    end
    ov_d = ov_q;
    if (s3_mv) begin
      ov_d = s3v_q;
    end else if (pop) begin
      if (ov_q[0]) begin
        ov_d[0] = 1'b0;
      end else begin
        ov_d[1] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      bp_q        <= '0;
      bp2_q       <= '0;
      orig_prev_q <= '0;
      s1v_q       <= '0;
      s2v_q       <= '0;
      s3v_q       <= '0;
      ov_q        <= '0;
    end else begin
      if (in_acc) begin
        column_q    <= column_d;
        bp_q        <= bright;
        bp2_q       <= bp2_d;
        orig_prev_q <= pix;
      end
      s1v_q <= s1v_d;
      s2v_q <= s2v_d;
      s3v_q <= s3v_d;
      ov_q  <= ov_d;
    end
  end

  bbpb_lane u_lane0 (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .gain_i  (gain_q),
    .orig_i  (orig_prev_q),
    .sum_i   (sum0),
    .pixel_o (lane0_pix)
  );

  bbpb_lane u_lane1 (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .gain_i  (gain_q),
    .orig_i  (pix),
    .sum_i   (sum1),
    .pixel_o (lane1_pix)
  );

  assign out_valid_o = |ov_q;
  assign pixel_out_o = ov_q[0] ? lane0_pix : lane1_pix;
  assign row_end_o   = !ov_q[0];

endmodule
`default_nettype wire

### src/bbpb_checker.sv
// Port-level checks for the bloom block, bound to the top level.
`default_nettype none
module bbpb_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [bbpb_pkg::OUT_W-1:0] pixel_out_o,
  input wire logic                       row_end_o
);

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_out_o <= bbpb_pkg::ONE_Q12))
    else $error("result above 1.0");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input held off with no result waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pixel_out_o) && $stable(row_end_o)))
    else $error("stalled result changed");

endmodule

bind bloom_bright_pass_box_blur bbpb_checker u_bbpb_checker (.*);
`default_nettype wire
